@@ rtl/rdq_pkg.sv @@
package rdq_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FILL_W  = 5;

  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ       = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
  } rdq_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_data;
    logic [STAT_W-1:0]         status;
    logic [FILL_W-1:0]         fill_count;
  } rdq_out_t;

  // per-item info carried alongside the memory read
  typedef struct packed {
    logic              hit_read;
    logic [STAT_W-1:0] status;
    logic [FILL_W-1:0] fill_count;
  } rdq_meta_t;

endpackage

@@ rtl/rdq_mem.sv @@
module rdq_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned DATA_W = 32,
  parameter int unsigned PTR_W  = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [PTR_W-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [PTR_W-1:0]  raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_q[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/rdq_ctrl.sv @@
module rdq_ctrl #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned DATA_W = 32,
  parameter int unsigned PTR_W  = 4,
  parameter int unsigned CNT_W  = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  rdq_pkg::rdq_in_t   item,
  output logic               mem_we,
  output logic [PTR_W-1:0]   mem_waddr,
  output logic [DATA_W-1:0]  mem_wdata,
  output logic               mem_re,
  output logic [PTR_W-1:0]   mem_raddr,
  output rdq_pkg::rdq_meta_t meta
);

  import rdq_pkg::*;

  localparam int unsigned CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam logic [PTR_W:0]   DEPTH_P = (PTR_W+1)'(DEPTH);
  localparam logic [PTR_W-1:0] LAST    = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(DEPTH);

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CMP_W-1:0] idx_ext;
  logic             full, empty, we_c, re_c, hit_read;
  logic [STAT_W-1:0] status;

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
    logic [PTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_P) begin
      s = s - DEPTH_P;
    end
    return s[PTR_W-1:0];
  endfunction

  assign full    = (count_r == FULL_C);
  assign empty   = (count_r == '0);
  assign idx_ext = CMP_W'(item.index);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    status    = ST_OK;
    hit_read  = 1'b0;
    we_c      = 1'b0;
    re_c      = 1'b0;
    mem_waddr = head_r;
    mem_raddr = wrap_add(head_r, idx_ext[PTR_W-1:0]);
    case (item.func)
      FUNC_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          we_c      = 1'b1;
          mem_waddr = wrap_add(head_r, count_r[PTR_W-1:0]);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FUNC_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          head_nxt  = (head_r == '0) ? LAST : head_r - PTR_W'(1);
          we_c      = 1'b1;
          mem_waddr = head_nxt;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FUNC_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      FUNC_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          head_nxt  = (head_r == LAST) ? '0 : head_r + PTR_W'(1);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      FUNC_READ: begin
        if (idx_ext >= CMP_W'(count_r)) begin
          status = ST_RANGE;
        end else begin
          re_c     = 1'b1;
          hit_read = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign mem_we          = accept && we_c;
  assign mem_re          = accept && re_c;
  assign mem_wdata       = DATA_W'($unsigned(item.value));
  assign meta.hit_read   = hit_read;
  assign meta.status     = status;
  assign meta.fill_count = FILL_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/ring_deque_with_indexed_read_top.sv @@
// channel | ports                          | payload
// input   | in_valid, in_stall, in_item    | rdq_in_t  (func, value, index)
// result  | out_valid, out_stall, out_item | rdq_out_t (read_data, status, fill_count)
//
// One item per cycle sustained unless out_stall holds the pipeline; each item's result passes
// through the registered read of the slot memory (read stage), then the result register.
// Reset clears head, count and valid flags; slot memory contents stay undefined until pushed.
// out_stall holds the result register, then the read stage, then raises in_stall.
module ring_deque_with_indexed_read_top #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rdq_pkg::rdq_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output rdq_pkg::rdq_out_t out_item
);

  import rdq_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic              accept, p1_adv;
  logic              mem_we, mem_re;
  logic [PTR_W-1:0]  mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;
  rdq_meta_t         meta;

  logic      p1_valid_r, out_valid_r;
  rdq_meta_t p1_meta_r;
  rdq_out_t  out_r;

  assign p1_adv   = !out_valid_r || !out_stall;
  assign in_stall = p1_valid_r && !p1_adv;
  assign accept   = in_valid && !in_stall;

  rdq_ctrl #(
    .DEPTH (DEPTH),
    .DATA_W(DATA_W),
    .PTR_W (PTR_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .meta     (meta)
  );

  rdq_mem #(
    .DEPTH (DEPTH),
    .DATA_W(DATA_W),
    .PTR_W (PTR_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        p1_valid_r <= 1'b1;
      end else if (p1_adv) begin
        p1_valid_r <= 1'b0;
      end
      if (p1_adv) begin
        out_valid_r <= p1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_meta_r <= meta;
    end
    if (p1_valid_r && p1_adv) begin
      out_r.read_data  <= p1_meta_r.hit_read ? VALUE_W'(mem_rdata) : '0;
      out_r.status     <= p1_meta_r.status;
      out_r.fill_count <= p1_meta_r.fill_count;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r && p1_meta_r.hit_read |-> p1_meta_r.status == ST_OK)
    else $error("read hit with non-ok status");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r && p1_adv |=> out_valid_r)
    else $error("read stage item lost");

  a_rdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r && p1_meta_r.hit_read && !p1_adv |=> $stable(mem_rdata))
    else $error("memory read data changed under stall");

endmodule

@@ tb/deque_result_checker.sv @@
module deque_result_checker
  import rdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  rdq_in_t  in_item,
  input  logic     out_valid,
  input  logic     out_stall,
  input  rdq_out_t out_item,
  output int       err_count,
  output int       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POS_W     = $clog2(DEPTH);
  localparam int          PRINT_CAP = 200;

  logic signed [VALUE_W-1:0] slot_mem [DEPTH];
  logic [POS_W-1:0]          front = '0;
  logic [FILL_W-1:0]         live  = '0;
  rdq_out_t                  expected_q [$];
  int                        mismatches = 0;
  int                        queued     = 0;

  assign err_count = mismatches;
  assign pending   = queued;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) begin
      $display("MISMATCH @%0t: %s", $time, what);
    end
    mismatches++;
  endtask

  // advances the deque image by one op and returns the result it should produce
  function automatic rdq_out_t apply_deque_op(input rdq_in_t op);
    rdq_out_t r;
    r = '0;
    r.status = ST_OK;
    case (op.func)
      FUNC_PUSH_BACK: begin
        if (live == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot_mem[POS_W'(front + live[POS_W-1:0])] = op.value;
          live++;
        end
      end
      FUNC_PUSH_FRONT: begin
        if (live == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          front = front - 1'b1;
          slot_mem[front] = op.value;
          live++;
        end
      end
      FUNC_POP_BACK: begin
        if (live == 0) begin
          r.status = ST_EMPTY;
        end else begin
          live--;
        end
      end
      FUNC_POP_FRONT: begin
        if (live == 0) begin
          r.status = ST_EMPTY;
        end else begin
          front = front + 1'b1;
          live--;
        end
      end
      FUNC_READ: begin
        if (FILL_W'(op.index) >= live) begin
          r.status = ST_RANGE;
        end else begin
          r.read_data = slot_mem[POS_W'(front + op.index)];
        end
      end
      default: ;
    endcase
    r.fill_count = live;
    return r;
  endfunction

  always @(posedge clk) begin
    rdq_out_t want;
    if (!rst_n) begin
      front = '0;
      live  = '0;
      expected_q.delete();
    end else begin
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        expected_q = {expected_q, apply_deque_op(in_item)};
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item %p", out_item));
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (out_item.read_data !== want.read_data) begin
            report_mismatch($sformatf("read_data %0d, want %0d",
                                      out_item.read_data, want.read_data));
          end
          if (out_item.status !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d",
                                      out_item.status, want.status));
          end
          if (out_item.fill_count !== want.fill_count) begin
            report_mismatch($sformatf("fill_count %0d, want %0d",
                                      out_item.fill_count, want.fill_count));
          end
        end
      end
    end
    queued <= expected_q.size();
  end

endmodule

@@ tb/tb_ring_deque_with_indexed_read_top.sv @@
module tb_ring_deque_with_indexed_read_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rdq_pkg::*;

  localparam int unsigned          DEPTH       = 16;
  localparam int                   RUN_ITEMS   = 1320;
  localparam int                   QUIET_ITEMS = 150;
  localparam int                   CYCLE_LIMIT = 400000;
  localparam logic [FUNC_W-1:0]    FUNC_NOP_LO = 3'd5;
  localparam logic [FUNC_W-1:0]    FUNC_NOP_HI = 3'd7;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  rdq_in_t  in_item   = '0;
  logic     out_stall = 1'b0;
  logic     quiet     = 1'b0;
  logic     in_stall;
  logic     out_valid;
  rdq_out_t out_item;
  int       errors;
  int       pending;
  int       hold_left = 0;
  int       free_left = 0;
  int       calm_left = 0;
  int       cycle_cnt = 0;

  logic signed [VALUE_W-1:0] extreme_vals [4] = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0, -32'sd1};

  always #5 clk = ~clk;

  ring_deque_with_indexed_read_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  deque_result_checker #(.DEPTH(DEPTH)) u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .err_count (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_ring_deque_with_indexed_read_top: done, errors");
      $finish;
    end
  end

  // result-side back pressure in bursts
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left <= free_left - 1;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      hold_left <= $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      free_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
      out_stall <= 1'b0;
    end
  end

  function automatic rdq_in_t make_op(input logic [FUNC_W-1:0] func,
                                      input logic signed [VALUE_W-1:0] value,
                                      input logic [INDEX_W-1:0] index);
    rdq_in_t op;
    op.func  = func;
    op.value = value;
    op.index = index;
    return op;
  endfunction

  function automatic rdq_in_t random_op(input mix_t mix);
    int push_w;
    int pop_w;
    int roll;
    logic [FUNC_W-1:0] func;
    logic signed [VALUE_W-1:0] value;
    push_w = (mix == MIX_GROW) ? 60 : (mix == MIX_SHRINK) ? 15 : 35;
    pop_w  = (mix == MIX_GROW) ? 15 : (mix == MIX_SHRINK) ? 60 : 30;
    roll   = $urandom_range(0, 99);
    if (roll < push_w) begin
      func = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
    end else if (roll < push_w + pop_w) begin
      func = $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
    end else if (roll < 97) begin
      func = FUNC_READ;
    end else begin
      func = FUNC_NOP_LO + FUNC_W'($urandom_range(0, 2));
    end
    value = ($urandom_range(0, 7) == 0) ? extreme_vals[$urandom_range(0, 3)] : $urandom;
    return make_op(func, value, INDEX_W'($urandom_range(0, 15)));
  endfunction

  task automatic drive_op(input rdq_in_t op);
    int gap;
    gap = 0;
    if (!quiet) begin
      if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 12);
      end else if ($urandom_range(0, 19) == 0) begin
        calm_left = $urandom_range(20, 60);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= op;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    mix_t mix;
    int   phase_left;
    mix        = MIX_EVEN;
    phase_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drive_op(make_op(FUNC_READ, 0, '0));
    drive_op(make_op(FUNC_POP_BACK, 0, '0));
    drive_op(make_op(FUNC_POP_FRONT, 0, '0));
    for (int i = 0; i < DEPTH; i++) begin
      drive_op(make_op(i[0] ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK,
                       (i < 4) ? extreme_vals[i] : $urandom, '0));
    end
    drive_op(make_op(FUNC_PUSH_BACK, $urandom, '0));
    drive_op(make_op(FUNC_PUSH_FRONT, $urandom, '0));
    drive_op(make_op(FUNC_READ, 0, 4'd15));
    drive_op(make_op(FUNC_READ, 0, '0));
    drive_op(make_op(FUNC_NOP_LO, $urandom, '0));
    drive_op(make_op(FUNC_NOP_HI, $urandom, 4'd15));
    drive_op(make_op(FUNC_POP_FRONT, 0, '0));
    drive_op(make_op(FUNC_POP_BACK, 0, '0));
    drive_op(make_op(FUNC_READ, 0, 4'd14));
    drive_op(make_op(FUNC_READ, 0, 4'd13));

    for (int n = 0; n < RUN_ITEMS; n++) begin
      if (phase_left == 0) begin
        mix        = mix_t'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 80);
      end
      if (n == RUN_ITEMS - QUIET_ITEMS) begin
        quiet <= 1'b1;
      end
      if (n == 500 || n == 900) begin
        wait_drained();
      end
      drive_op(random_op(mix));
      phase_left--;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (5) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_ring_deque_with_indexed_read_top: done, clean");
    end else begin
      $display("tb_ring_deque_with_indexed_read_top: done, errors");
    end
    $finish;
  end

endmodule
